// ===== design/pun_pkg.sv =====
// ----------------------------------------------------------------------------
// pun_pkg: shared types and codes of the polygon unit normal block
// Word formats, status codes, datapath commands and multiplier selects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pun_pkg;

	localparam int MAX_POINTS_DEF = 64;

	// configuration register reset values and indexes
	localparam logic [47:0] AREA_TOL_RST = 48'd1;
	localparam logic [30:0] COS_TOL_RST  = 31'd1073578293;
	localparam logic REG_AREA_TOL = 1'b0;
	localparam logic REG_COS_TOL  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_FEW  = 3'd1;
	localparam logic [2:0] ST_COLL = 3'd2;
	localparam logic [2:0] ST_NCOP = 3'd3;
	localparam logic [2:0] ST_MANY = 3'd4;

	// datapath operations
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_LD_P0  = 4'd1;
	localparam logic [3:0] OP_LD_P1  = 4'd2;
	localparam logic [3:0] OP_LD_PK  = 4'd3;
	localparam logic [3:0] OP_DIFF   = 4'd4;
	localparam logic [3:0] OP_CRA    = 4'd5;
	localparam logic [3:0] OP_CRB    = 4'd6;
	localparam logic [3:0] OP_SEED   = 4'd7;
	localparam logic [3:0] OP_BEST   = 4'd8;
	localparam logic [3:0] OP_MUL    = 4'd9;
	localparam logic [3:0] OP_CANDSQ = 4'd10;
	localparam logic [3:0] OP_UOUT   = 4'd11;
	localparam logic [3:0] OP_EMIT   = 4'd12;

	// shift-add multiplier operand selects
	localparam logic [3:0] MS_AREA  = 4'd0;
	localparam logic [3:0] MS_COS   = 4'd1;
	localparam logic [3:0] MS_SQ    = 4'd2;
	localparam logic [3:0] MS_DOT   = 4'd3;
	localparam logic [3:0] MS_DOT2  = 4'd4;
	localparam logic [3:0] MS_RHS1  = 4'd5;
	localparam logic [3:0] MS_RHS2  = 4'd6;
	localparam logic [3:0] MS_USQ   = 4'd7;
	localparam logic [3:0] MS_UCAND = 4'd8;

	typedef struct packed {
		logic signed [23:0] x_coord;
		logic signed [23:0] y_coord;
		logic signed [23:0] z_coord;
		logic               last_point;
	} pt_word_t;

	typedef struct packed {
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic [2:0]         status;
	} nrm_word_t;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] msel;
		logic [1:0] idx;
		logic [4:0] bitpos;
		logic [2:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic degen;
		logic aligned;
		logic bigger;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== design/polygon_unit_normal_unit.sv =====
// Loading: points load at one per cycle while pt_stall is low; after the last point
//   the result word is computed on the shared shift-add multiplier.
// Throughput: one polygon at a time; points stall from the last point until the
//   result is in the output register.
// Reset: control and output valid clear, configuration registers return to defaults, store undefined.
// ----------------------------------------------------------------------------
// polygon_unit_normal_unit: unit normal of a planar polygon
// Stores the points of one polygon and emits its normalized Q1.30 normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polygon_unit_normal_unit
	import pun_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pt_valid,
	output logic             pt_stall,
	input  wire pt_word_t    pt_word,
	output logic             nrm_valid,
	input  wire logic        nrm_stall,
	output nrm_word_t        nrm_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    wr_en;
	logic [$clog2(MAX_POINTS)-1:0] wr_addr, rd_addr;

	// configuration words are taken in any cycle
	assign cfg_ready = 1'b1;

	pun_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_stall   (pt_stall),
		.last_point (pt_word.last_point),
		.nrm_valid  (nrm_valid),
		.nrm_stall  (nrm_stall),
		.cmd        (cmd),
		.sts        (sts),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr)
	);

	pun_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.pt_word   (pt_word),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.nrm_word  (nrm_word)
	);

endmodule

`default_nettype wire

// ===== design/pun_dp.sv =====
// ----------------------------------------------------------------------------
// pun_dp: datapath of the polygon unit normal block
// Point store, cross products, shared shift-add multiplier and result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pun_dp
	import pun_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dp_cmd_t                       cmd,
	output dp_sts_t                            sts,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	input  wire pt_word_t                      pt_word,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_index,
	input  wire logic [47:0]                   cfg_data,
	output nrm_word_t                          nrm_word
);

	localparam int AccW = 272;
	localparam int BW   = 104;

	function automatic logic [50:0] mag51(input logic signed [50:0] v);
		return v[50] ? $unsigned(-v) : $unsigned(v);
	endfunction

	logic [47:0] area_tol_q;
	logic [30:0] cos_tol_q;

	logic [71:0] mem [MAX_POINTS];
	logic [71:0] rdata_q;
	logic signed [23:0] rd_pt [3];

	logic signed [23:0] p0_q [3];
	logic signed [23:0] p1_q [3];
	logic signed [23:0] pk_q [3];
	logic signed [24:0] da_q [3];
	logic signed [24:0] db_q [3];
	logic signed [49:0] prod_q;
	logic signed [50:0] c_q [3];
	logic signed [50:0] seed_q [3];
	logic signed [50:0] best_q [3];
	logic [103:0] sc_q, sseed_q, sbest_q;
	logic [97:0]  lim_q;
	logic [61:0]  cos2_q;
	logic signed [105:0] dot_q;
	logic [271:0] lhs_q, rhs_q;
	logic [165:0] tmp_q;
	logic [163:0] urhs_q;
	logic [30:0]  q_q, cand_q;
	logic [63:0]  csq_q;
	logic         usign_q, dsign_q;
	logic [31:0]  ucomp_q [3];
	nrm_word_t    nrm_q;

	// multiplier state
	logic [AccW-1:0] ma_q, acc_q;
	logic [BW-1:0]   mb_q;
	logic [6:0]      mcnt_q;
	logic            busy_q, done_q;
	logic [3:0]      msel_q;
	logic [1:0]      midx_q;

	logic [AccW-1:0] mux_a;
	logic [BW-1:0]   mux_b;
	logic [6:0]      mux_n;
	logic [105:0]    dot_abs;
	logic [1:0]      cu, cv;
	logic signed [49:0] cr_a, cr_b;
	logic [30:0]     cand_w;
	logic [31:0]     odd_w;
	logic [63:0]     csq_w;
	logic            start;
	logic            ok_st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_tol_q <= AREA_TOL_RST;
			cos_tol_q  <= COS_TOL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_AREA_TOL: area_tol_q <= cfg_data;
				REG_COS_TOL:  cos_tol_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// point store: write on load, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {pt_word.x_coord, pt_word.y_coord, pt_word.z_coord};
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	assign rd_pt[0] = rdata_q[71:48];
	assign rd_pt[1] = rdata_q[47:24];
	assign rd_pt[2] = rdata_q[23:0];

	// cross product term pairs
	always_comb begin
		case (cmd.idx)
			2'd0:    begin cu = 2'd1; cv = 2'd2; end
			2'd1:    begin cu = 2'd2; cv = 2'd0; end
			default: begin cu = 2'd0; cv = 2'd1; end
		endcase
		cr_a = da_q[cu] * db_q[cv];
		cr_b = da_q[cv] * db_q[cu];
	end

	// next candidate bit of the normalized component
	always_comb begin
		cand_w = q_q | (31'd1 << cmd.bitpos);
		odd_w  = {cand_w, 1'b0} - 32'd1;
		csq_w  = odd_w * odd_w;
	end

	assign dot_abs = dot_q[105] ? $unsigned(-dot_q) : $unsigned(dot_q);

	// multiplier operand select
	always_comb begin
		mux_a = '0;
		mux_b = '0;
		mux_n = 7'd1;
		case (cmd.msel)
			MS_AREA: begin
				mux_a = AccW'(area_tol_q); mux_b = BW'(area_tol_q); mux_n = 7'd48;
			end
			MS_COS: begin
				mux_a = AccW'(cos_tol_q); mux_b = BW'(cos_tol_q); mux_n = 7'd31;
			end
			MS_SQ: begin
				mux_a = AccW'(mag51(c_q[cmd.idx]));
				mux_b = BW'(mag51(c_q[cmd.idx]));
				mux_n = 7'd51;
			end
			MS_DOT: begin
				mux_a = AccW'(mag51(seed_q[cmd.idx]));
				mux_b = BW'(mag51(c_q[cmd.idx]));
				mux_n = 7'd51;
			end
			MS_DOT2: begin
				mux_a = AccW'(dot_abs[103:0]); mux_b = dot_abs[103:0]; mux_n = 7'd104;
			end
			MS_RHS1: begin
				mux_a = AccW'(sseed_q); mux_b = BW'(cos2_q); mux_n = 7'd62;
			end
			MS_RHS2: begin
				mux_a = AccW'(tmp_q); mux_b = sc_q; mux_n = 7'd104;
			end
			MS_USQ: begin
				mux_a = AccW'(mag51(best_q[cmd.idx]));
				mux_b = BW'(mag51(best_q[cmd.idx]));
				mux_n = 7'd51;
			end
			MS_UCAND: begin
				mux_a = AccW'(sbest_q); mux_b = BW'(csq_q); mux_n = 7'd64;
			end
			default: ;
		endcase
	end

	assign start = (cmd.op == OP_MUL);

	// multiplier control: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			done_q <= busy_q && (mcnt_q == 7'd1) && !start;
			if (start) begin
				busy_q <= 1'b1;
				mcnt_q <= mux_n;
			end else if (busy_q) begin
				mcnt_q <= mcnt_q - 7'd1;
				if (mcnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// multiplier operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q    <= mux_a;
			mb_q    <= mux_b;
			acc_q   <= '0;
			msel_q  <= cmd.msel;
			midx_q  <= cmd.idx;
			dsign_q <= seed_q[cmd.idx][50] ^ c_q[cmd.idx][50];
		end else if (busy_q) begin
			if (mb_q[0]) begin
				acc_q <= acc_q + ma_q;
			end
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

	assign ok_st = (cmd.status == ST_OK) || (cmd.status == ST_MANY);

	// datapath registers: commanded steps and multiplier results
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LD_P0: for (int i = 0; i < 3; i++) p0_q[i] <= rd_pt[i];
			OP_LD_P1: for (int i = 0; i < 3; i++) p1_q[i] <= rd_pt[i];
			OP_LD_PK: for (int i = 0; i < 3; i++) pk_q[i] <= rd_pt[i];
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					da_q[i] <= {p1_q[i][23], p1_q[i]} - {p0_q[i][23], p0_q[i]};
					db_q[i] <= {pk_q[i][23], pk_q[i]} - {p0_q[i][23], p0_q[i]};
				end
			end
			OP_CRA: prod_q <= cr_a;
			OP_CRB: c_q[cmd.idx] <= {prod_q[49], prod_q} - {cr_b[49], cr_b};
			OP_SEED: begin
				for (int i = 0; i < 3; i++) begin
					seed_q[i] <= c_q[i];
					best_q[i] <= c_q[i];
				end
				sseed_q <= sc_q;
				sbest_q <= sc_q;
			end
			OP_BEST: begin
				for (int i = 0; i < 3; i++) best_q[i] <= c_q[i];
				sbest_q <= sc_q;
			end
			OP_CANDSQ: begin
				cand_q <= cand_w;
				csq_q  <= csq_w;
			end
			OP_UOUT: ucomp_q[cmd.idx] <= usign_q ? 32'd0 - {1'b0, q_q} : {1'b0, q_q};
			OP_EMIT: begin
				nrm_q.norm_x <= ok_st ? ucomp_q[0] : 32'd0;
				nrm_q.norm_y <= ok_st ? ucomp_q[1] : 32'd0;
				nrm_q.norm_z <= ok_st ? ucomp_q[2] : 32'd0;
				nrm_q.status <= cmd.status;
			end
			default: ;
		endcase
		if (done_q) begin
			case (msel_q)
				MS_AREA: lim_q  <= {acc_q[95:0], 2'b00};
				MS_COS:  cos2_q <= acc_q[61:0];
				MS_SQ:   sc_q   <= ((midx_q == 2'd0) ? 104'd0 : sc_q) + {2'b00, acc_q[101:0]};
				MS_DOT: begin
					if (dsign_q) begin
						dot_q <= ((midx_q == 2'd0) ? 106'sd0 : dot_q)
							- $signed({4'd0, acc_q[101:0]});
					end else begin
						dot_q <= ((midx_q == 2'd0) ? 106'sd0 : dot_q)
							+ $signed({4'd0, acc_q[101:0]});
					end
				end
				MS_DOT2: lhs_q <= {acc_q[211:0], 60'd0};
				MS_RHS1: tmp_q <= acc_q[165:0];
				MS_RHS2: rhs_q <= acc_q;
				MS_USQ: begin
					urhs_q  <= {acc_q[101:0], 62'd0};
					q_q     <= '0;
					usign_q <= best_q[midx_q][50];
				end
				MS_UCAND: begin
					if (acc_q <= {108'd0, urhs_q} && cand_q <= 31'h4000_0000) begin
						q_q <= cand_q;
					end
				end
				default: ;
			endcase
		end
	end

	// status toward the controller
	assign sts.mul_busy = busy_q;
	assign sts.mul_done = done_q;
	assign sts.degen    = (c_q[0] == 51'sd0 && c_q[1] == 51'sd0 && c_q[2] == 51'sd0)
		|| (sc_q < {6'd0, lim_q});
	assign sts.aligned  = (lhs_q >= rhs_q);
	assign sts.bigger   = (sc_q > sbest_q);

	assign nrm_word = nrm_q;

endmodule

`default_nettype wire

// ===== design/pun_ctrl.sv =====
// ----------------------------------------------------------------------------
// pun_ctrl: controller of the polygon unit normal block
// Loads points, steps the seed search, coplanarity checks and normalization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pun_ctrl
	import pun_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pt_valid,
	output logic                               pt_stall,
	input  wire logic                          last_point,
	output logic                               nrm_valid,
	input  wire logic                          nrm_stall,
	output dp_cmd_t                            cmd,
	input  wire dp_sts_t                       sts,
	output logic                               wr_en,
	output logic [$clog2(MAX_POINTS)-1:0]      wr_addr,
	output logic [$clog2(MAX_POINTS)-1:0]      rd_addr
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_COS   = 5'd2;
	localparam logic [4:0] S_SEED0 = 5'd3;
	localparam logic [4:0] S_RD1   = 5'd4;
	localparam logic [4:0] S_RD2   = 5'd5;
	localparam logic [4:0] S_RD3   = 5'd6;
	localparam logic [4:0] S_DIFF  = 5'd7;
	localparam logic [4:0] S_CRA   = 5'd8;
	localparam logic [4:0] S_CRB   = 5'd9;
	localparam logic [4:0] S_SQ    = 5'd10;
	localparam logic [4:0] S_TEST  = 5'd11;
	localparam logic [4:0] S_NEXTK = 5'd12;
	localparam logic [4:0] S_DOT   = 5'd13;
	localparam logic [4:0] S_DOT2  = 5'd14;
	localparam logic [4:0] S_RHS1  = 5'd15;
	localparam logic [4:0] S_RHS2  = 5'd16;
	localparam logic [4:0] S_ALIGN = 5'd17;
	localparam logic [4:0] S_USQ   = 5'd18;
	localparam logic [4:0] S_UQ    = 5'd19;
	localparam logic [4:0] S_UMUL  = 5'd20;
	localparam logic [4:0] S_UOUT  = 5'd21;
	localparam logic [4:0] S_EMIT  = 5'd22;
	localparam logic [4:0] S_MWAIT = 5'd23;

	logic [4:0]    state_q, state_d, ret_q, ret_d;
	logic [CW-1:0] cnt_q, cnt_d, r_q, r_d, k_q, k_d;
	logic          ovf_q, ovf_d, seeding_q, seeding_d, nrm_valid_q, nrm_valid_d;
	logic [1:0]    j_q, j_d;
	logic [4:0]    bit_q, bit_d;
	logic [2:0]    st_q, st_d;
	logic [CW-1:0] off_w;
	logic [CW:0]   sum_w, wrap_w;
	logic          accept;

	assign pt_stall  = (state_q != S_LOAD);
	assign accept    = pt_valid && !pt_stall;
	assign wr_en     = accept && (cnt_q < MAX_CNT);
	assign wr_addr   = cnt_q[AW-1:0];
	assign nrm_valid = nrm_valid_q;

	// read address: (r + offset) mod n
	always_comb begin
		case (state_q)
			S_SEED0: off_w = '0;
			S_RD1:   off_w = CW'(1);
			default: off_w = k_q;
		endcase
		sum_w  = {1'b0, r_q} + {1'b0, off_w};
		wrap_w = (sum_w >= {1'b0, cnt_q}) ? sum_w - {1'b0, cnt_q} : sum_w;
	end
	assign rd_addr = wrap_w[AW-1:0];

	// sequencer
	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cnt_d       = cnt_q;
		ovf_d       = ovf_q;
		r_d         = r_q;
		k_d         = k_q;
		j_d         = j_q;
		bit_d       = bit_q;
		st_d        = st_q;
		seeding_d   = seeding_q;
		nrm_valid_d = nrm_valid_q && nrm_stall;
		cmd         = '0;
		cmd.op      = OP_NOP;
		cmd.idx     = j_q;
		cmd.bitpos  = bit_q;
		cmd.status  = st_q;
		case (state_q)
			S_LOAD: begin
				if (accept) begin
					if (cnt_q < MAX_CNT) begin
						cnt_d = cnt_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last_point) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				r_d       = '0;
				k_d       = CW'(2);
				seeding_d = 1'b1;
				if (cnt_q < CW'(3)) begin
					st_d    = ST_FEW;
					state_d = S_EMIT;
				end else begin
					cmd.op   = OP_MUL;
					cmd.msel = MS_AREA;
					ret_d    = S_COS;
					state_d  = S_MWAIT;
				end
			end
			S_COS: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_COS;
				ret_d    = S_SEED0;
				state_d  = S_MWAIT;
			end
			S_SEED0: state_d = S_RD1;
			S_RD1: begin
				cmd.op  = OP_LD_P0;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.op  = OP_LD_P1;
				state_d = S_RD3;
			end
			S_RD3: begin
				cmd.op  = OP_LD_PK;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				j_d     = 2'd0;
				state_d = S_CRA;
			end
			S_CRA: begin
				cmd.op  = OP_CRA;
				state_d = S_CRB;
			end
			S_CRB: begin
				cmd.op = OP_CRB;
				if (j_q == 2'd2) begin
					j_d     = 2'd0;
					state_d = S_SQ;
				end else begin
					j_d     = j_q + 2'd1;
					state_d = S_CRA;
				end
			end
			S_SQ: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_SQ;
				ret_d    = (j_q == 2'd2) ? S_TEST : S_SQ;
				j_d      = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
				state_d  = S_MWAIT;
			end
			S_TEST: begin
				if (seeding_q) begin
					if (!sts.degen) begin
						cmd.op    = OP_SEED;
						seeding_d = 1'b0;
						k_d       = CW'(3);
						state_d   = S_NEXTK;
					end else if (r_q == cnt_q - CW'(1)) begin
						st_d    = ST_COLL;
						state_d = S_EMIT;
					end else begin
						r_d     = r_q + CW'(1);
						state_d = S_SEED0;
					end
				end else if (sts.degen) begin
					k_d     = k_q + CW'(1);
					state_d = S_NEXTK;
				end else begin
					j_d     = 2'd0;
					state_d = S_DOT;
				end
			end
			S_NEXTK: begin
				j_d = 2'd0;
				if (k_q >= cnt_q) begin
					state_d = S_USQ;
				end else begin
					state_d = S_RD3;
				end
			end
			S_DOT: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_DOT;
				ret_d    = (j_q == 2'd2) ? S_DOT2 : S_DOT;
				j_d      = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
				state_d  = S_MWAIT;
			end
			S_DOT2: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_DOT2;
				ret_d    = S_RHS1;
				state_d  = S_MWAIT;
			end
			S_RHS1: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_RHS1;
				ret_d    = S_RHS2;
				state_d  = S_MWAIT;
			end
			S_RHS2: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_RHS2;
				ret_d    = S_ALIGN;
				state_d  = S_MWAIT;
			end
			S_ALIGN: begin
				if (!sts.aligned) begin
					st_d    = ST_NCOP;
					state_d = S_EMIT;
				end else begin
					if (sts.bigger) begin
						cmd.op = OP_BEST;
					end
					k_d     = k_q + CW'(1);
					state_d = S_NEXTK;
				end
			end
			S_USQ: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_USQ;
				bit_d    = 5'd30;
				ret_d    = S_UQ;
				state_d  = S_MWAIT;
			end
			S_UQ: begin
				cmd.op  = OP_CANDSQ;
				state_d = S_UMUL;
			end
			S_UMUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_UCAND;
				ret_d    = (bit_q == 5'd0) ? S_UOUT : S_UQ;
				bit_d    = bit_q - 5'd1;
				state_d  = S_MWAIT;
			end
			S_UOUT: begin
				cmd.op = OP_UOUT;
				if (j_q == 2'd2) begin
					st_d    = ovf_q ? ST_MANY : ST_OK;
					state_d = S_EMIT;
				end else begin
					j_d     = j_q + 2'd1;
					state_d = S_USQ;
				end
			end
			S_EMIT: begin
				// hold until the output register is free
				if (!nrm_valid_q || !nrm_stall) begin
					cmd.op      = OP_EMIT;
					nrm_valid_d = 1'b1;
					cnt_d       = '0;
					ovf_d       = 1'b0;
					state_d     = S_LOAD;
				end
			end
			S_MWAIT: begin
				if (sts.mul_done) begin
					state_d = ret_q;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ret_q       <= S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			r_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			bit_q       <= '0;
			st_q        <= ST_OK;
			seeding_q   <= 1'b0;
			nrm_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			cnt_q       <= cnt_d;
			ovf_q       <= ovf_d;
			r_q         <= r_d;
			k_q         <= k_d;
			j_q         <= j_d;
			bit_q       <= bit_d;
			st_q        <= st_d;
			seeding_q   <= seeding_d;
			nrm_valid_q <= nrm_valid_d;
		end
	end

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == MAX_CNT))
		else $error("overflow flag set with store not full");

	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEST) |-> (r_q < cnt_q))
		else $error("seed rotation beyond point count");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MUL) |-> !sts.mul_busy)
		else $error("multiply issued while multiplier busy");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |=> nrm_valid)
		else $error("emitted word not presented");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == S_MWAIT))
		else $error("multiply finished outside wait state");

endmodule

`default_nettype wire

// ===== test/polygon_unit_normal_unit_tb.sv =====
// ----------------------------------------------------------------------------
// polygon_unit_normal_unit_tb: self-checking bench for the polygon normal unit
// Sends polygons point by point under random bursts and output stalls, predicts
// each normal and status with exact wide integer math, and compares every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_unit_normal_unit_tb;
	import pun_pkg::*;

	typedef bit [319:0] wide_t;
	typedef struct {
		longint c[3];
	} vec_t;

	localparam int  NPTS      = 64;
	localparam longint LIMIT  = 40000000;

	logic        clk;
	logic        arst_n;
	logic        pt_valid;
	logic        pt_stall;
	pt_word_t    pt_word;
	logic        nrm_valid;
	logic        nrm_stall;
	nrm_word_t   nrm_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [47:0] cfg_data;

	polygon_unit_normal_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall), .pt_word(pt_word),
		.nrm_valid(nrm_valid), .nrm_stall(nrm_stall), .nrm_word(nrm_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	bit [47:0]   area_lim;
	bit [30:0]   cos_lim;
	int          pts_x[NPTS];
	int          pts_y[NPTS];
	int          pts_z[NPTS];
	int          pts_n;
	bit          pts_ovf;
	nrm_word_t   normal_q[$];
	pt_word_t    poly_q[$];
	int          errors;
	longint      cycles;
	bit          hold_req;
	int          burst_left;

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic vec_t tri_cross(int i0, int i1, int i2);
		longint ax, ay, az, bx, by, bz;
		vec_t n;
		ax = longint'(pts_x[i1]) - pts_x[i0];
		ay = longint'(pts_y[i1]) - pts_y[i0];
		az = longint'(pts_z[i1]) - pts_z[i0];
		bx = longint'(pts_x[i2]) - pts_x[i0];
		by = longint'(pts_y[i2]) - pts_y[i0];
		bz = longint'(pts_z[i2]) - pts_z[i0];
		n.c[0] = ay * bz - az * by;
		n.c[1] = az * bx - ax * bz;
		n.c[2] = ax * by - ay * bx;
		return n;
	endfunction

	function automatic wide_t len_sq(vec_t v);
		wide_t s;
		wide_t m;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			m = mag(v.c[k]);
			s += m * m;
		end
		return s;
	endfunction

	function automatic bit is_degen(vec_t v, wide_t sq);
		wide_t lim;
		if (v.c[0] == 0 && v.c[1] == 0 && v.c[2] == 0)
			return 1'b1;
		lim = area_lim;
		lim = lim * lim * 4;
		return sq < lim;
	endfunction

	// unoriented coplanarity: dot^2 * 2^60 >= cos^2 * |a|^2 * |b|^2
	function automatic bit is_coplanar(vec_t a, wide_t sa, vec_t b, wide_t sb);
		wide_t pos, neg, t, lhs, rhs;
		pos = '0;
		neg = '0;
		for (int k = 0; k < 3; k++) begin
			t = mag(a.c[k]);
			t = t * wide_t'(mag(b.c[k]));
			if ((a.c[k] < 0) != (b.c[k] < 0))
				neg += t;
			else
				pos += t;
		end
		lhs = (pos >= neg) ? pos - neg : neg - pos;
		lhs = (lhs * lhs) << 60;
		rhs = cos_lim;
		rhs = rhs * rhs * sa * sb;
		return lhs >= rhs;
	endfunction

	// rounded Q1.30 component by bitwise search
	function automatic logic signed [31:0] unit_part(longint comp, wide_t sq);
		wide_t rhs, lhs, m;
		longint unsigned q, cand;
		m = mag(comp);
		rhs = (m * m) << 62;
		q = 0;
		for (int b = 30; b >= 0; b--) begin
			cand = q | (64'd1 << b);
			if (cand <= (64'd1 << 30)) begin
				lhs = 2 * cand - 1;
				lhs = lhs * lhs * sq;
				if (lhs <= rhs)
					q = cand;
			end
		end
		if (comp < 0)
			q = -q;
		return q[31:0];
	endfunction

	function automatic nrm_word_t predict_normal();
		nrm_word_t res;
		vec_t seed, best, c;
		wide_t s_seed, s_best, s_c;
		int r;
		bit found;
		res = '0;
		if (pts_n < 3) begin
			res.status = ST_FEW;
			return res;
		end
		found = 1'b0;
		for (r = 0; r < pts_n && !found; r++) begin
			seed = tri_cross(r, (r + 1) % pts_n, (r + 2) % pts_n);
			s_seed = len_sq(seed);
			if (!is_degen(seed, s_seed))
				found = 1'b1;
		end
		if (!found) begin
			res.status = ST_COLL;
			return res;
		end
		r--;
		best = seed;
		s_best = s_seed;
		for (int k = 3; k < pts_n; k++) begin
			c = tri_cross(r, (r + 1) % pts_n, (r + k) % pts_n);
			s_c = len_sq(c);
			if (!is_degen(c, s_c)) begin
				if (!is_coplanar(seed, s_seed, c, s_c)) begin
					res.status = ST_NCOP;
					return res;
				end
				if (s_c > s_best) begin
					best = c;
					s_best = s_c;
				end
			end
		end
		res.norm_x = unit_part(best.c[0], s_best);
		res.norm_y = unit_part(best.c[1], s_best);
		res.norm_z = unit_part(best.c[2], s_best);
		res.status = pts_ovf ? ST_MANY : ST_OK;
		return res;
	endfunction

	// store accepted points, predict on the last one
	always @(posedge clk) begin
		if (arst_n && pt_valid && !pt_stall) begin
			if (pts_n < NPTS) begin
				pts_x[pts_n] = pt_word.x_coord;
				pts_y[pts_n] = pt_word.y_coord;
				pts_z[pts_n] = pt_word.z_coord;
				pts_n++;
			end else
				pts_ovf = 1'b1;
			if (pt_word.last_point) begin
				normal_q = {normal_q, predict_normal()};
				pts_n = 0;
				pts_ovf = 1'b0;
			end
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		nrm_word_t exp_w;
		if (arst_n && nrm_valid && !nrm_stall) begin
			if (normal_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, nrm_word);
			end else begin
				exp_w = normal_q.pop_front();
				if (nrm_word.norm_x !== exp_w.norm_x) begin
					errors++;
					$display("%0t: norm_x exp %0d got %0d", $time, exp_w.norm_x,
						nrm_word.norm_x);
				end
				if (nrm_word.norm_y !== exp_w.norm_y) begin
					errors++;
					$display("%0t: norm_y exp %0d got %0d", $time, exp_w.norm_y,
						nrm_word.norm_y);
				end
				if (nrm_word.norm_z !== exp_w.norm_z) begin
					errors++;
					$display("%0t: norm_z exp %0d got %0d", $time, exp_w.norm_z,
						nrm_word.norm_z);
				end
				if (nrm_word.status !== exp_w.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, exp_w.status,
						nrm_word.status);
				end
			end
		end
	end

	// output stall: long hold on request, else shifting random patterns
	initial begin
		int mode, left, held;
		nrm_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				nrm_stall <= 1'b1;
				held++;
				if (held >= 30000) begin
					hold_req = 1'b0;
					held = 0;
				end
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(50, 400);
				end
				left--;
				case (mode)
					0: nrm_stall <= 1'b0;
					1: nrm_stall <= ($urandom_range(0, 3) == 0);
					default: nrm_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// send one point word, with burst gaps; called at a falling edge
	task automatic send_point(pt_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pt_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pt_valid <= 1'b1;
		pt_word <= w;
		@(posedge clk);
		while (pt_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// send the queued points, flagging the last, then drop valid
	task automatic send_polygon();
		pt_word_t w;
		while (poly_q.size() > 0) begin
			w = poly_q.pop_front();
			w.last_point = (poly_q.size() == 0);
			send_point(w);
		end
		pt_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_point(int x, int y, int z);
		pt_word_t w;
		w.x_coord = 24'(x);
		w.y_coord = 24'(y);
		w.z_coord = 24'(z);
		w.last_point = 1'b0;
		poly_q = {poly_q, w};
	endtask

	task automatic wait_drain();
		while (normal_q.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// write one register, then drop valid and idle with it low
	task automatic write_reg(logic idx, logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_AREA_TOL)
			area_lim = val;
		else
			cos_lim = val[30:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// planar polygon: base + a*u + b*v with small integer a, b
	task automatic build_planar(int n, int span);
		int bx, by, bz, ux, uy, uz, vx, vy, vz, a, b;
		bx = $urandom_range(0, 2097152) - 1048576;
		by = $urandom_range(0, 2097152) - 1048576;
		bz = $urandom_range(0, 2097152) - 1048576;
		ux = $urandom_range(0, 2 * span) - span;
		uy = $urandom_range(0, 2 * span) - span;
		uz = $urandom_range(0, 2 * span) - span;
		vx = $urandom_range(0, 2 * span) - span;
		vy = $urandom_range(0, 2 * span) - span;
		vz = $urandom_range(0, 2 * span) - span;
		for (int i = 0; i < n; i++) begin
			a = $urandom_range(0, 16) - 8;
			b = $urandom_range(0, 16) - 8;
			add_point(bx + a * ux + b * vx, by + a * uy + b * vy, bz + a * uz + b * vz);
		end
	endtask

	task automatic build_noise(int n);
		for (int i = 0; i < n; i++)
			add_point($signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
				$signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
				$signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8);
	endtask

	task automatic build_line(int n);
		int bx, by, bz, dx, dy, dz, a;
		bx = $urandom_range(0, 200000) - 100000;
		by = $urandom_range(0, 200000) - 100000;
		bz = $urandom_range(0, 200000) - 100000;
		dx = $urandom_range(0, 2000) - 1000;
		dy = $urandom_range(0, 2000) - 1000;
		dz = $urandom_range(0, 2000) - 1000;
		for (int i = 0; i < n; i++) begin
			a = $urandom_range(0, 100) - 50;
			add_point(bx + a * dx, by + a * dy, bz + a * dz);
		end
	endtask

	// field extremes, all bits of each coordinate both ways
	task automatic test_extremes();
		add_point(-8388608, -8388608, 8388607);
		add_point(8388607, -8388608, -8388608);
		add_point(-8388608, 8388607, -8388608);
		send_polygon();
		add_point(8388607, 8388607, 8388607);
		add_point(-8388608, 0, 0);
		add_point(0, -8388608, 0);
		add_point(0, 0, 8388607);
		send_polygon();
	endtask

	// fewer than three points
	task automatic test_short();
		add_point(5, 6, 7);
		send_polygon();
		add_point(1, 2, 3);
		add_point(100, 2, 3);
		send_polygon();
	endtask

	// all collinear, a degenerate seed that needs rotation, and random noise
	task automatic test_collinear();
		build_line(5);
		send_polygon();
		add_point(0, 0, 0);
		add_point(0, 0, 0);
		add_point(4096, 0, 0);
		add_point(4096, 4096, 0);
		add_point(0, 4096, 0);
		send_polygon();
		build_noise(5);
		send_polygon();
	endtask

	// too many points: excess dropped, status from stored points
	task automatic test_overflow();
		build_planar(NPTS + 3, 3000);
		send_polygon();
		build_line(NPTS + 1);
		send_polygon();
	endtask

	task automatic test_zero_tol();
		wait_drain();
		write_reg(REG_AREA_TOL, 48'd0);
		add_point(0, 0, 0);
		add_point(1, 0, 0);
		add_point(2, 1, 0);
		send_polygon();
		add_point(7, 7, 7);
		add_point(7, 7, 7);
		add_point(7, 7, 7);
		send_polygon();
		wait_drain();
		write_reg(REG_AREA_TOL, 48'hFFFF_FFFF_FFFF);
		build_planar(4, 50000);
		send_polygon();
		wait_drain();
		write_reg(REG_AREA_TOL, AREA_TOL_RST);
	endtask

	// cosine limits: above one fails extra triangles, zero passes all
	task automatic test_cos_limits();
		wait_drain();
		write_reg(REG_COS_TOL, 48'h7FFF_FFFF);
		build_planar(5, 4000);
		send_polygon();
		wait_drain();
		write_reg(REG_COS_TOL, 48'd0);
		build_noise(5);
		send_polygon();
		wait_drain();
		write_reg(REG_COS_TOL, 48'd1073741824);
		build_planar(5, 4000);
		send_polygon();
		wait_drain();
		write_reg(REG_COS_TOL, COS_TOL_RST);
	endtask

	// long output hold while points keep coming, then a full drain
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 4; i++) begin
			build_planar(4, 2000);
			send_polygon();
		end
		wait_drain();
	endtask

	task automatic test_random(int target);
		int sent, n, kind;
		sent = 0;
		while (sent < target) begin
			if (sent > 0 && $urandom_range(0, 39) == 0) begin
				wait_drain();
				write_reg(REG_AREA_TOL, $urandom_range(0, 3) == 0 ? 48'd0 :
					48'($urandom_range(1, 5000)));
				write_reg(REG_COS_TOL, 48'(1073741824 - $urandom_range(0, 1000000)));
			end
			kind = $urandom_range(0, 9);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 7);
			if (kind < 7)
				build_planar(n, $urandom_range(1, 30000));
			else if (kind == 7)
				build_noise($urandom_range(1, 6));
			else if (kind == 8)
				build_line(n);
			else begin
				add_point(0, 0, 0);
				add_point(0, 0, 0);
				build_planar(n, 500);
			end
			sent += poly_q.size();
			send_polygon();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pt_valid = 1'b0;
		pt_word = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_AREA_TOL;
		cfg_data = '0;
		area_lim = AREA_TOL_RST;
		cos_lim = COS_TOL_RST;
		pts_n = 0;
		pts_ovf = 1'b0;
		errors = 0;
		cycles = 0;
		hold_req = 1'b0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_extremes();
		test_short();
		test_collinear();
		test_zero_tol();
		test_cos_limits();
		test_overflow();
		test_backpressure();
		test_random(700);
		wait_drain();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
